/* rtl/ptd_pkg.sv */
package ptd_pkg;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_FREE  = 3'd1,
    OP_START = 3'd2,
    OP_STOP  = 3'd3,
    OP_TICK  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_FREE = 2'd0,
    ST_STOP = 2'd1,
    ST_RUN  = 2'd2
  } slot_st_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN_ADD,
    S_SCAN_TICK,
    S_END
  } ctrl_st_t;

  localparam logic [1:0] K_ACK      = 2'd0;
  localparam logic [1:0] K_DISPATCH = 2'd1;
  localparam logic [1:0] K_END      = 2'd2;

  localparam logic [1:0] C_OK      = 2'd0;
  localparam logic [1:0] C_NOSPACE = 2'd1;
  localparam logic [1:0] C_NOENTRY = 2'd2;
  localparam logic [1:0] C_NOTIMER = 2'd3;

  localparam int ID_BITS = 4;

  // Command broadcast from the controller to every cell of the row.
  typedef struct packed {
    logic               scan_add;
    logic               scan_tick;
    logic               set_free;
    logic               set_run;
    logic               set_stop;
    logic [ID_BITS-1:0] id;
  } cell_cmd_t;

endpackage

/* rtl/ptd_cell.sv */
module ptd_cell
  import ptd_pkg::*;
#(
  parameter int IDX       = 0,
  parameter int TIME_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 tok_in,
  output logic                 tok_out,
  input  cell_cmd_t            cmd,
  input  logic [TIME_BITS-1:0] now,
  input  logic [TIME_BITS-1:0] first_due,
  input  logic [TIME_BITS-1:0] period,
  input  logic                 run_init,
  output logic                 is_free,
  output logic                 hit
);

  slot_st_t             st;
  logic [TIME_BITS-1:0] due;
  logic [TIME_BITS-1:0] per;
  logic                 addressed;
  logic                 claim;
  logic                 fire;

  assign addressed = (int'(cmd.id) == IDX);
  assign is_free   = (st == ST_FREE);
  assign claim     = tok_in && cmd.scan_add && (st == ST_FREE);
  assign fire      = tok_in && cmd.scan_tick && (st == ST_RUN) && (now >= due);
  assign hit       = claim || fire;

  // The scan token moves one cell per cycle; an add token dies in the cell
  // that takes it, a tick token runs off the end of the row.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= 1'b0;
    end else begin
      tok_out <= tok_in && !claim;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_FREE;
    end else if (claim) begin
      st <= run_init ? ST_RUN : ST_STOP;
    end else if (addressed && cmd.set_free) begin
      st <= ST_FREE;
    end else if (addressed && cmd.set_run && st != ST_FREE) begin
      st <= ST_RUN;
    end else if (addressed && cmd.set_stop && st != ST_FREE) begin
      st <= ST_STOP;
    end
  end

  always_ff @(posedge clk) begin
    if (claim) begin
      due <= first_due;
      per <= period;
    end else if (fire) begin
      due <= due + per;
    end
  end

endmodule

/* rtl/ptd_ctrl.sv */
module ptd_ctrl
  import ptd_pkg::*;
#(
  parameter int NUM_SLOTS = 16,
  parameter int TIME_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [2:0]           op,
  input  logic [ID_BITS-1:0]   task_id,
  input  logic [TIME_BITS-1:0] period,
  input  logic [TIME_BITS-1:0] first_due,
  input  logic                 start_running,
  input  logic                 has_entry,
  input  logic                 has_timer,
  input  logic [TIME_BITS-1:0] now,
  output logic                 strobe,
  output logic [1:0]           kind,
  output logic [3:0]           slot,
  output logic [1:0]           code,
  output logic                 last,
  output cell_cmd_t            cmd,
  output logic                 launch,
  output logic [TIME_BITS-1:0] now_q,
  output logic [TIME_BITS-1:0] first_due_q,
  output logic [TIME_BITS-1:0] period_q,
  output logic                 run_q,
  input  logic [NUM_SLOTS-1:0] free_vec,
  input  logic [NUM_SLOTS-1:0] hit_vec
);

  localparam int PW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  ctrl_st_t      state, state_next;
  logic [PW-1:0] pos, pos_next;
  logic          launch_next;
  logic          strobe_next;
  logic [1:0]    kind_next;
  logic [3:0]    slot_next;
  logic [1:0]    code_next;
  logic          last_next;
  logic          accept;
  logic          any_free;
  logic          any_hit;
  logic          id_ok;
  logic          id_free;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign any_free = |free_vec;
  assign any_hit  = |hit_vec;
  assign id_ok    = (int'(task_id) < NUM_SLOTS);

  always_comb begin
    id_free = 1'b0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (int'(task_id) == i) begin
        id_free = free_vec[i];
      end
    end
  end

  always_comb begin
    state_next  = state;
    pos_next    = pos;
    launch_next = 1'b0;
    strobe_next = 1'b0;
    kind_next   = K_ACK;
    slot_next   = '0;
    code_next   = C_OK;
    last_next   = 1'b1;
    cmd         = '0;
    cmd.id      = task_id;
    cmd.scan_add  = (state == S_SCAN_ADD);
    cmd.scan_tick = (state == S_SCAN_TICK);
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (op_t'(op))
            OP_ADD: begin
              if (!any_free) begin
                strobe_next = 1'b1;
                code_next   = C_NOSPACE;
              end else if (!has_entry) begin
                strobe_next = 1'b1;
                code_next   = C_NOENTRY;
              end else if (!has_timer) begin
                strobe_next = 1'b1;
                code_next   = C_NOTIMER;
              end else begin
                state_next  = S_SCAN_ADD;
                pos_next    = '0;
                launch_next = 1'b1;
              end
            end
            OP_FREE, OP_START, OP_STOP: begin
              strobe_next = 1'b1;
              slot_next   = task_id;
              if (!id_ok) begin
                code_next = C_NOSPACE;
              end else if (op_t'(op) == OP_FREE) begin
                cmd.set_free = 1'b1;
              end else if (id_free) begin
                code_next = C_NOSPACE;
              end else begin
                cmd.set_run  = (op_t'(op) == OP_START);
                cmd.set_stop = (op_t'(op) == OP_STOP);
              end
            end
            OP_TICK: begin
              state_next  = S_SCAN_TICK;
              pos_next    = '0;
              launch_next = 1'b1;
            end
            default: begin
              strobe_next = 1'b1;
              code_next   = C_NOSPACE;
            end
          endcase
        end
      end
      S_SCAN_ADD: begin
        pos_next = pos + 1'b1;
        if (any_hit) begin
          strobe_next = 1'b1;
          slot_next   = 4'(pos);
          state_next  = S_IDLE;
        end
      end
      S_SCAN_TICK: begin
        pos_next = pos + 1'b1;
        if (any_hit) begin
          strobe_next = 1'b1;
          kind_next   = K_DISPATCH;
          slot_next   = 4'(pos);
          last_next   = 1'b0;
        end
        if (pos == PW'(NUM_SLOTS - 1)) begin
          state_next = S_END;
        end
      end
      S_END: begin
        strobe_next = 1'b1;
        kind_next   = K_END;
        state_next  = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      pos    <= '0;
      launch <= 1'b0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      pos    <= pos_next;
      launch <= launch_next;
      strobe <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    kind <= kind_next;
    slot <= slot_next;
    code <= code_next;
    last <= last_next;
    if (accept) begin
      now_q       <= now;
      first_due_q <= first_due;
      period_q    <= period;
      run_q       <= start_running;
    end
  end

`ifndef ASSERT_OFF
  a_one_hit: assert property (@(posedge clk) disable iff (rst)
    $onehot0(hit_vec))
    else $error("more than one cell reports a hit");

  a_add_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN_ADD && any_hit) |=> (state == S_IDLE && strobe && code == C_OK))
    else $error("claimed slot not acknowledged");

  a_hit_scan: assert property (@(posedge clk) disable iff (rst)
    any_hit |-> (state == S_SCAN_ADD || state == S_SCAN_TICK))
    else $error("cell hit outside a scan");

  a_reset: assert property (@(posedge clk)
    rst |=> (!strobe && !busy))
    else $error("reset left output or busy set");
`endif

endmodule

/* rtl/periodic_task_dispatcher_top.sv */
// Periodic task dispatcher: a row of NUM_SLOTS task cells behind a small
// command controller.
// Input: present op and its fields with start high while busy is low; the
// word is taken at that edge. Output: each result word sits on kind, slot,
// code and last for exactly one cycle with strobe high; the receiver cannot
// stall, so every strobed word must be taken when it appears.
// Free, start, stop, unknown ops and failing adds answer in the cycle after the
// accept and the block is ready again at once (one item per cycle).
// A successful add walks a token down the row to the lowest free cell, one
// cell per cycle, and the acknowledge carries that cell's number in slot.
// A tick walks the token over every cell: dispatches appear in slot order as
// the token passes, and the tick end word follows once the token leaves the
// row; busy stays high through the walk and drops as the end word appears.
// The token's walk along the row paces these answers.
// Reset marks every slot free, clears busy and the token, and drops strobe.
module periodic_task_dispatcher_top
  import ptd_pkg::*;
#(
  parameter int NUM_SLOTS = 16,
  parameter int TIME_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [2:0]           op,
  input  logic [3:0]           task_id,
  input  logic [TIME_BITS-1:0] period,
  input  logic [TIME_BITS-1:0] first_due,
  input  logic                 start_running,
  input  logic                 has_entry,
  input  logic                 has_timer,
  input  logic [TIME_BITS-1:0] now,
  output logic                 strobe,
  output logic [1:0]           kind,
  output logic [3:0]           slot,
  output logic [1:0]           code,
  output logic                 last
);

  cell_cmd_t            cmd;
  logic                 launch;
  logic [TIME_BITS-1:0] now_q;
  logic [TIME_BITS-1:0] first_due_q;
  logic [TIME_BITS-1:0] period_q;
  logic                 run_q;
  logic [NUM_SLOTS-1:0] free_vec;
  logic [NUM_SLOTS-1:0] hit_vec;
  logic [NUM_SLOTS:0]   tok;

  assign tok[0] = launch;

  ptd_ctrl #(
    .NUM_SLOTS(NUM_SLOTS),
    .TIME_BITS(TIME_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .op           (op),
    .task_id      (task_id),
    .period       (period),
    .first_due    (first_due),
    .start_running(start_running),
    .has_entry    (has_entry),
    .has_timer    (has_timer),
    .now          (now),
    .strobe       (strobe),
    .kind         (kind),
    .slot         (slot),
    .code         (code),
    .last         (last),
    .cmd          (cmd),
    .launch       (launch),
    .now_q        (now_q),
    .first_due_q  (first_due_q),
    .period_q     (period_q),
    .run_q        (run_q),
    .free_vec     (free_vec),
    .hit_vec      (hit_vec)
  );

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    ptd_cell #(
      .IDX      (i),
      .TIME_BITS(TIME_BITS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .tok_in   (tok[i]),
      .tok_out  (tok[i+1]),
      .cmd      (cmd),
      .now      (now_q),
      .first_due(first_due_q),
      .period   (period_q),
      .run_init (run_q),
      .is_free  (free_vec[i]),
      .hit      (hit_vec[i])
    );
  end

`ifndef ASSERT_OFF
  a_idle_no_token: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (tok[NUM_SLOTS-1:0] == '0))
    else $error("scan token left in the row while idle");
`endif

endmodule
